/* design/agnn_pkg.sv */
package agnn_pkg;

    localparam int MAX_PARTICLES = 256;
    localparam int COORD_BITS    = 16;
    localparam int IDX_W         = 8;
    localparam int AREA_W        = 16;
    localparam int MARGIN_W      = 16;
    localparam int SIZE_W        = IDX_W + 1;
    localparam int ADDR_W        = $clog2(MAX_PARTICLES);
    localparam int RADIUS_W      = 18;
    localparam int DIFF_W        = COORD_BITS + 1;
    localparam int SQ_W          = 2 * DIFF_W;
    localparam int D2_W          = SQ_W + 2;
    localparam int ROOT_W        = (D2_W + 1) / 2;
    localparam int PROD_W        = AREA_W + MARGIN_W;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(384);
    localparam logic [RADIUS_W-1:0] RADIUS_MAX   = '1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } pos_word_t;

    typedef struct packed {
        logic               req_type;
        logic [IDX_W-1:0]   index;
        logic [AREA_W-1:0]  area;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic               last;
    } req_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic                found;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QLATCH,
        ST_SCAN,
        ST_DRAIN,
        ST_SQRT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_we;
        logic capture;
        logic q_latch;
        logic scan_en;
        logic sqrt_start;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic q_in_range;
        logic scan_last;
        logic pipe_empty;
        logic found;
        logic sqrt_done;
    } stat_t;

endpackage

/* design/area_gated_nearest_neighbor.sv */
// channel  | handshake               | word
// request  | start && !busy          | req    (req_t)
// result   | done, one cycle strobe  | result (result_t)
// config   | cfg_we                  | cfg_data (area margin, Q8.8)
//
// Load: the next word may follow at once.
// Query with a match: the time for a set of N particles is set by the one-per-cycle
// scan over the particle memory read port and the 18-step square root; no match skips the root.
// Out-of-range query: no scan. Reset clears set size and margin to 1.5.
// Results cannot be stalled; busy holds off requests during a query.
module area_gated_nearest_neighbor
    import agnn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  req_t                req,
    output logic                done,
    output result_t             result,
    input  logic                cfg_we,
    input  logic [MARGIN_W-1:0] cfg_data
);

    ctrl_t cmd;
    stat_t stat;

    agnn_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    agnn_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result)
    );

    assign done = cmd.emit;

endmodule

/* design/agnn_sqrt.sv */
module agnn_sqrt
    import agnn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [D2_W-1:0]   operand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int N_W   = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [N_W-1:0]    n_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], n_reg[N_W-1 -: 2]};
        trial  = REM_W'({root_reg, 2'b01});
        take   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= N_W'(operand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            n_reg    <= {n_reg[N_W-3:0], 2'b00};
            rem_reg  <= take ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* design/agnn_datapath.sv */
module agnn_datapath
    import agnn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  req_t                req,
    input  logic                cfg_we,
    input  logic [MARGIN_W-1:0] cfg_data,
    input  ctrl_t               cmd,
    output stat_t               stat,
    output result_t             result
);

    localparam int SAT_W = (ROOT_W > RADIUS_W) ? ROOT_W : RADIUS_W;

    pos_word_t             pos_mem  [MAX_PARTICLES];
    logic [AREA_W-1:0]     area_mem [MAX_PARTICLES];

    logic [MARGIN_W-1:0]   margin_reg;
    logic [SIZE_W-1:0]     set_size_reg;
    logic [IDX_W-1:0]      qidx_reg;
    logic [SIZE_W-1:0]     cnt_reg;

    pos_word_t             rd_pos_reg;
    logic [AREA_W-1:0]     rd_area_reg;
    pos_word_t             qpos_reg;
    logic [AREA_W-1:0]     qarea_reg;
    logic [PROD_W-1:0]     hi_reg;

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  self1_reg, self2_reg;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg, sqz_reg;
    logic [PROD_W-1:0]     am_reg;
    logic                  gate_hi_reg;
    logic [D2_W-1:0]       sum_reg;
    logic                  qual3_reg;
    logic [D2_W-1:0]       best_reg;
    logic                  found_reg;

    logic [ADDR_W-1:0]     rd_addr;
    pos_word_t             wr_pos;
    logic [DIFF_W-1:0]     mx, my, mz;
    logic                  qual2;
    logic [ROOT_W-1:0]     root;
    logic                  sqrt_done;
    logic [SAT_W-1:0]      root_ext;
    logic [RADIUS_W-1:0]   radius_sat;

    function automatic logic [DIFF_W-1:0] abs_diff(coord_t a, coord_t b);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    always_comb
    begin
        wr_pos.x = coord_t'(req.pos_x);
        wr_pos.y = coord_t'(req.pos_y);
        wr_pos.z = coord_t'(req.pos_z);
        rd_addr  = cmd.capture ? ADDR_W'(req.index) : ADDR_W'(cnt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            pos_mem[ADDR_W'(req.index)]  <= wr_pos;
            area_mem[ADDR_W'(req.index)] <= req.area;
        end
        rd_pos_reg  <= pos_mem[rd_addr];
        rd_area_reg <= area_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg   <= MARGIN_RESET;
            set_size_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                margin_reg <= cfg_data;
            end
            if (cmd.load_we && req.last)
            begin
                set_size_reg <= SIZE_W'(req.index) + 1'b1;
            end
        end
    end

    // query capture and scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.q_latch)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.scan_en)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            qidx_reg <= req.index;
        end
        if (cmd.q_latch)
        begin
            qpos_reg  <= rd_pos_reg;
            qarea_reg <= rd_area_reg;
            hi_reg    <= rd_area_reg * margin_reg;
        end
    end

    always_comb
    begin
        mx    = abs_diff(qpos_reg.x, rd_pos_reg.x);
        my    = abs_diff(qpos_reg.y, rd_pos_reg.y);
        mz    = abs_diff(qpos_reg.z, rd_pos_reg.z);
        qual2 = v2_reg && !self2_reg && gate_hi_reg
             && (am_reg > PROD_W'({qarea_reg, 8'h00}));
    end

    // scan pipeline: read, square, sum, keep best
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.scan_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.q_latch)
            begin
                found_reg <= 1'b0;
            end
            else if (v3_reg && qual3_reg && (!found_reg || sum_reg < best_reg))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        self1_reg   <= cnt_reg == SIZE_W'(qidx_reg);
        self2_reg   <= self1_reg;
        sqx_reg     <= mx * mx;
        sqy_reg     <= my * my;
        sqz_reg     <= mz * mz;
        am_reg      <= rd_area_reg * margin_reg;
        gate_hi_reg <= PROD_W'({rd_area_reg, 8'h00}) < hi_reg;
        sum_reg     <= D2_W'(sqx_reg) + D2_W'(sqy_reg) + D2_W'(sqz_reg);
        qual3_reg   <= qual2;
        if (v3_reg && qual3_reg && (!found_reg || sum_reg < best_reg))
        begin
            best_reg <= sum_reg;
        end
    end

    agnn_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.sqrt_start),
        .operand (best_reg),
        .done    (sqrt_done),
        .root    (root)
    );

    always_comb
    begin
        root_ext   = SAT_W'(root);
        radius_sat = (root_ext > SAT_W'(RADIUS_MAX)) ? RADIUS_MAX : RADIUS_W'(root_ext);
        stat.q_in_range = SIZE_W'(qidx_reg) < set_size_reg;
        stat.scan_last  = (cnt_reg + 1'b1) == set_size_reg;
        stat.pipe_empty = !v1_reg && !v2_reg && !v3_reg;
        stat.found      = found_reg;
        stat.sqrt_done  = sqrt_done;
        result.found    = found_reg;
        result.radius   = found_reg ? radius_sat : RADIUS_MAX;
    end

`ifndef NO_ASSERTIONS
    a_sqrt_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_start |-> (!v1_reg && !v2_reg && !v3_reg && found_reg))
        else $error("sqrt started with scan pipeline busy or nothing found");
`endif

endmodule

/* design/agnn_ctrl.sv */
module agnn_ctrl
    import agnn_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  req_t  req,
    input  stat_t stat,
    output ctrl_t cmd,
    output logic  busy
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = state_reg != ST_IDLE;
        accept     = start && !busy;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.req_type == REQ_LOAD)
                begin
                    cmd.load_we = 32'(req.index) < 32'(MAX_PARTICLES);
                end
                else if (accept && req.req_type == REQ_QUERY)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_QLATCH;
                end
            end
            ST_QLATCH:
            begin
                cmd.q_latch = 1'b1;
                state_next  = stat.q_in_range ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    cmd.sqrt_start = stat.found;
                    state_next     = stat.found ? ST_SQRT : ST_DONE;
                end
            end
            ST_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.req_type == REQ_QUERY) |=> busy)
        else $error("query accepted but block not busy");

    a_emit_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (!cmd.emit && !busy))
        else $error("result strobe longer than one cycle");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_en |-> stat.q_in_range)
        else $error("scan running for out-of-range query");
`endif

endmodule

/* verif/area_gated_nearest_neighbor_tb.sv */
module area_gated_nearest_neighbor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import agnn_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 30;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    req_t                req;
    logic                done;
    result_t             result;
    logic                cfg_we;
    logic [MARGIN_W-1:0] cfg_data;

    logic [AREA_W-1:0]   particle_area [MAX_PARTICLES];
    logic signed [15:0]  particle_pos  [MAX_PARTICLES][3];
    logic [SIZE_W-1:0]   live_set_size;
    logic [MARGIN_W-1:0] live_margin;
    result_t             pending_results [$];
    int                  errors;
    int                  items_sent;
    int                  sender_idle_pct;

    area_gated_nearest_neighbor uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(4_000_000);
        $display("Verification failed");
        $finish;
    end

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 20; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    function automatic result_t nearest_match(int q);
        result_t         r;
        longint unsigned aq;
        longint unsigned ai;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned d2;
        longint unsigned best;
        longint unsigned root;
        longint          dx;
        longint          dy;
        longint          dz;
        bit              hit;
        r.found  = 1'b0;
        r.radius = RADIUS_MAX;
        hit      = 1'b0;
        best     = 0;
        if (q < live_set_size)
        begin
            aq = particle_area[q];
            hi = aq * live_margin;
            lo = aq * 256;
            for (int i = 0; i < live_set_size; i++)
            begin
                if (i == q)
                    continue;
                ai = particle_area[i];
                if (ai * 256 < hi && ai * live_margin > lo)
                begin
                    dx = longint'(particle_pos[q][0]) - longint'(particle_pos[i][0]);
                    dy = longint'(particle_pos[q][1]) - longint'(particle_pos[i][1]);
                    dz = longint'(particle_pos[q][2]) - longint'(particle_pos[i][2]);
                    d2 = dx * dx + dy * dy + dz * dz;
                    if (!hit || d2 < best)
                    begin
                        best = d2;
                        hit  = 1'b1;
                    end
                end
            end
        end
        if (hit)
        begin
            root     = floor_sqrt(best);
            r.found  = 1'b1;
            r.radius = (root > RADIUS_MAX) ? RADIUS_MAX : RADIUS_W'(root);
        end
        return r;
    endfunction

    function automatic req_t load_word(int idx, int area, logic signed [15:0] x,
                                       logic signed [15:0] y, logic signed [15:0] z,
                                       bit last);
        req_t w;
        w.req_type = REQ_LOAD;
        w.index    = IDX_W'(idx);
        w.area     = AREA_W'(area);
        w.pos_x    = x;
        w.pos_y    = y;
        w.pos_z    = z;
        w.last     = last;
        return w;
    endfunction

    function automatic req_t query_word(int idx);
        req_t w;
        w          = '0;
        w.req_type = REQ_QUERY;
        w.index    = IDX_W'(idx);
        w.area     = AREA_W'($urandom);
        w.pos_x    = 16'($urandom);
        w.pos_y    = 16'($urandom);
        w.pos_z    = 16'($urandom);
        w.last     = 1'($urandom);
        return w;
    endfunction

    // start is left high; the next call or a gap decides at the next falling edge
    task automatic send_word(req_t w);
        @(negedge clk);
        start <= 1'b1;
        req   <= w;
        do
            @(posedge clk);
        while (busy);
        if (w.req_type == REQ_QUERY)
            pending_results.push_back(nearest_match(w.index));
        else
        begin
            particle_area[w.index]   = w.area;
            particle_pos[w.index][0] = w.pos_x;
            particle_pos[w.index][1] = w.pos_y;
            particle_pos[w.index][2] = w.pos_z;
            if (w.last)
                live_set_size = {1'b0, w.index} + 9'd1;
        end
        items_sent++;
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_margin(int value);
        wait_drained();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= MARGIN_W'(value);
        @(negedge clk);
        cfg_we   <= 1'b0;
        live_margin = MARGIN_W'(value);
    endtask

    function automatic int random_margin();
        case ($urandom_range(9))
            0:       return $urandom_range(0, 255);
            1:       return 65535;
            2:       return 256;
            3:       return $urandom_range(0, 65535);
            default: return $urandom_range(257, 1024);
        endcase
    endfunction

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no query outstanding");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.radius !== want.radius)
                begin
                    $error("radius expected %0d actual %0d", want.radius, result.radius);
                    errors++;
                end
                if (result.found !== want.found)
                begin
                    $error("found expected %0d actual %0d", want.found, result.found);
                    errors++;
                end
            end
        end
    end

    task automatic test_empty_set();
        send_word(query_word(0));
        send_word(query_word(255));
        wait_drained();
    endtask

    task automatic test_field_extremes();
        send_word(load_word(0, 65535, 16'h8000, 16'h8000, 16'h8000, 1'b0));
        send_word(load_word(1, 65535, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
        send_word(load_word(2, 0, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        send_word(query_word(0));
        send_word(query_word(1));
        send_word(query_word(2));
        send_word(query_word(3));
        send_word(query_word(255));
        wait_drained();
    endtask

    task automatic test_lone_particle();
        send_word(load_word(0, 500, 16'sd1, 16'sd2, 16'sd3, 1'b1));
        send_word(query_word(0));
        wait_drained();
    endtask

    task automatic test_margin_extremes();
        int margins [4] = '{0, 256, 65535, 257};
        send_word(load_word(0, 100, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_word(load_word(1, 120, 16'sd16, 16'sd0, 16'sd0, 1'b0));
        send_word(load_word(2, 100, 16'sd0, 16'sd48, 16'sd0, 1'b1));
        foreach (margins[m])
        begin
            write_margin(margins[m]);
            for (int q = 0; q < 3; q++)
                send_word(query_word(q));
        end
        write_margin(MARGIN_RESET);
    endtask

    task automatic load_and_query_set(int n, int n_queries);
        int                 order [MAX_PARTICLES];
        int                 j;
        int                 tmp;
        int                 slot;
        int                 base;
        int                 a;
        int                 spread;
        logic signed [15:0] center [3];
        logic signed [15:0] coord  [3];
        for (int k = 0; k < n; k++)
            order[k] = k;
        for (int k = n - 1; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        base   = $urandom_range(1, 65535);
        spread = $urandom_range(1) ? $urandom_range(1, 2048) : 0;
        for (int c = 0; c < 3; c++)
            center[c] = 16'($urandom);
        for (int k = 0; k < n; k++)
        begin
            slot = order[k];
            if ($urandom_range(3) == 0)
                a = $urandom_range(0, 65535);
            else
            begin
                a = base + int'($urandom_range(0, base / 2)) - base / 4;
                if (a > 65535)
                    a = 65535;
            end
            for (int c = 0; c < 3; c++)
                coord[c] = (spread != 0)
                    ? 16'(center[c] + int'($urandom_range(0, 2 * spread)) - spread)
                    : 16'($urandom);
            send_word(load_word(slot, a, coord[0], coord[1], coord[2], slot == n - 1));
            sender_gap();
        end
        // stray load outside the set, or a reload that may shrink the set
        case ($urandom_range(7))
            0:
                if (n < MAX_PARTICLES)
                    send_word(load_word($urandom_range(n, 255), $urandom_range(0, 65535),
                                        16'($urandom), 16'($urandom), 16'($urandom), 1'b0));
            1:
                send_word(load_word($urandom_range(0, n - 1), $urandom_range(0, 65535),
                                    16'($urandom), 16'($urandom), 16'($urandom), 1'b1));
            default: ;
        endcase
        for (int k = 0; k < n_queries; k++)
        begin
            if ($urandom_range(9) == 0)
                send_word(query_word($urandom_range(0, 255)));
            else
                send_word(query_word($urandom_range(0, n - 1)));
            sender_gap();
        end
    endtask

    task automatic test_random_sets(int idle_pct, int n_items, bit with_full_set);
        int first;
        int n;
        int r;
        sender_idle_pct = idle_pct;
        first           = items_sent;
        if (with_full_set)
            load_and_query_set(MAX_PARTICLES, 4);
        while (items_sent - first < n_items)
        begin
            if ($urandom_range(9) == 0)
                write_margin(random_margin());
            r = $urandom_range(99);
            if (r < 5)
                n = 1;
            else if (r < 85)
                n = $urandom_range(2, 12);
            else if (r < 97)
                n = $urandom_range(13, 64);
            else
                n = $urandom_range(65, 255);
            load_and_query_set(n, $urandom_range(n / 2 + 1, 2 * n + 2));
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        req             = '0;
        cfg_we          = 1'b0;
        cfg_data        = MARGIN_RESET;
        errors          = 0;
        items_sent      = 0;
        sender_idle_pct = 0;
        live_set_size   = '0;
        live_margin     = MARGIN_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_set();
        test_field_extremes();
        test_lone_particle();
        test_margin_extremes();
        test_random_sets(16, 260, 1'b0);
        test_random_sets(49, 260, 1'b0);
        test_random_sets(0, 300, 1'b1);

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
